### design/atcw_pkg.sv
// Shared constants and types for the ANSI text console writer.
package atcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [7:0]  DEFAULT_ATTR_RST = 8'd15;
  localparam logic [31:0] PALETTE_RST      = 32'd4082229824;

  localparam logic REG_DEFAULT_ATTR = 1'b0;
  localparam logic REG_PALETTE      = 1'b1;

  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_PCT  = 8'h25;
  localparam logic [7:0] CH_LBRK = 8'h5B;
  localparam logic [7:0] CH_M    = 8'h6D;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;

  localparam logic [6:0] SGR_RESET = 7'd0;
  localparam logic [6:0] SGR_FG_LO = 7'd30;
  localparam logic [6:0] SGR_FG_HI = 7'd37;
  localparam logic [6:0] SGR_MAX   = 7'd99;
  localparam logic [7:0] ATTR_HI_MASK = 8'hF0;

  typedef enum logic [3:0] {
    MODE_TEXT = 4'b0001,
    MODE_ESC  = 4'b0010,
    MODE_CSI  = 4'b0100,
    MODE_PCT  = 4'b1000
  } mode_t;

endpackage

### design/ansi_text_console_writer.sv
// ANSI text console writer: escape parser, cursor tracking and result queue.
//
// One character word is taken per clock unless input is stalled. Parsing,
// the attribute update and the cursor step (two chained cursor steps for
// a lone ESC followed by a character other than [, ESC or %) are done
// combinationally between the input and a three-entry result queue. A word
// yields zero, one or two result words; with the output side taking a word
// each cycle, input runs at one word per clock until words that yield two
// results fill the queue. Input stalls only when more than one result is
// still waiting after this cycle's output transfer. The cursor is kept as
// a linear index plus a column count, so newlines and wrap need only adds
// and compares. There is no clearing pass; the block accepts input from
// the first cycle after reset.
module ansi_text_console_writer #(
  parameter int COLUMNS = atcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = atcw_pkg::ROWS_DEF,
  localparam int CW     = ($clog2(COLUMNS * ROWS) > 0) ? $clog2(COLUMNS * ROWS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    char_code,
  input  logic          message_start,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          cell_write,
  output logic [CW-1:0] cell_index,
  output logic [7:0]    glyph,
  output logic [7:0]    attribute,
  output logic          screen_clear,
  output logic [CW-1:0] cursor_index,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import atcw_pkg::*;

  localparam int LIMIT = COLUMNS * ROWS;
  localparam int COLW  = ($clog2(COLUMNS) > 0) ? $clog2(COLUMNS) : 1;

  typedef struct packed {
    logic          cell_write;
    logic [CW-1:0] cell_index;
    logic [7:0]    glyph;
    logic [7:0]    attribute;
    logic          screen_clear;
    logic [CW-1:0] cursor_index;
  } res_t;

  typedef struct packed {
    res_t            res;
    logic [CW-1:0]   cur;
    logic [COLW-1:0] col;
  } put_t;

  function automatic put_t put_char(input logic [7:0] c, input logic [CW-1:0] cur,
                                    input logic [COLW-1:0] col, input logic [7:0] attr);
    put_t            p;
    logic            nl;
    logic            clr;
    logic [CW:0]     nxt;
    logic [COLW-1:0] ncol;
    nl = (c == CH_NL);
    p.res.cell_write = !nl;
    p.res.cell_index = nl ? '0 : cur;
    p.res.glyph      = nl ? 8'd0 : c;
    p.res.attribute  = nl ? 8'd0 : attr;
    if (nl) begin
      nxt  = (CW+1)'(cur) - (CW+1)'(col) + (CW+1)'(COLUMNS);
      ncol = '0;
    end else begin
      nxt  = (CW+1)'(cur) + 1'b1;
      ncol = (col == COLW'(COLUMNS - 1)) ? '0 : col + 1'b1;
    end
    clr = (nxt >= (CW+1)'(LIMIT));
    p.cur = clr ? '0 : nxt[CW-1:0];
    p.col = clr ? '0 : ncol;
    p.res.screen_clear = clr;
    p.res.cursor_index = p.cur;
    return p;
  endfunction

  // configuration registers
  logic [7:0]  default_attr;
  logic [31:0] palette;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_attr <= DEFAULT_ATTR_RST;
      palette      <= PALETTE_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_DEFAULT_ATTR: default_attr <= pwdata[7:0];
        REG_PALETTE:      palette      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DEFAULT_ATTR: prdata = {24'd0, default_attr};
      REG_PALETTE:      prdata = palette;
      default:          prdata = '0;
    endcase
  end

  // parser and cursor state
  mode_t           mode, mode_next;
  logic [6:0]      sgr, sgr_next;
  logic [7:0]      attr, attr_next;
  logic [CW-1:0]   cursor, cursor_next;
  logic [COLW-1:0] col, col_next;

  // result queue
  res_t       q [3];
  res_t       q_next [3];
  logic [1:0] cnt, cnt_next;

  logic       pop, acc;
  logic [1:0] rem, n;
  res_t       r0, r1;
  mode_t      mode_eff;
  logic [6:0] sgr_eff;
  logic [7:0] attr_eff;
  logic [9:0] prod;
  logic [2:0] fg_idx;
  put_t       p1, p2;
  logic [1:0] wi;

  assign out_valid = (cnt != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign rem       = cnt - 2'(pop);
  assign in_stall  = (rem > 2'd1);
  assign acc       = in_valid && !in_stall;

  always_comb begin
    mode_eff = message_start ? MODE_TEXT : mode;
    sgr_eff  = message_start ? SGR_RESET : sgr;
    attr_eff = message_start ? default_attr : attr;
    mode_next   = mode_eff;
    sgr_next    = sgr_eff;
    attr_next   = attr_eff;
    cursor_next = cursor;
    col_next    = col;
    n  = 2'd0;
    r0 = '0;
    r1 = '0;
    prod   = 10'(sgr_eff) * 10'd10 + 10'(char_code - CH_0);
    fg_idx = 3'(sgr_eff - SGR_FG_LO);
    p1 = put_char(char_code, cursor, col, attr_eff);
    p2 = p1;
    case (mode_eff)
      MODE_ESC: begin
        if (char_code == CH_LBRK) begin
          mode_next = MODE_CSI;
          sgr_next  = SGR_RESET;
        end else begin
          p1 = put_char(CH_ESC, cursor, col, attr_eff);
          r0 = p1.res;
          n  = 2'd1;
          cursor_next = p1.cur;
          col_next    = p1.col;
          if (char_code == CH_ESC) begin
            mode_next = MODE_ESC;
          end else if (char_code == CH_PCT) begin
            mode_next = MODE_PCT;
          end else begin
            mode_next = MODE_TEXT;
            p2 = put_char(char_code, p1.cur, p1.col, attr_eff);
            r1 = p2.res;
            n  = 2'd2;
            cursor_next = p2.cur;
            col_next    = p2.col;
          end
        end
      end
      MODE_CSI: begin
        if (char_code inside {[CH_0:CH_9]}) begin
          sgr_next = (prod > 10'(SGR_MAX)) ? SGR_MAX : prod[6:0];
        end else if (char_code == CH_M) begin
          mode_next = MODE_TEXT;
          sgr_next  = SGR_RESET;
          if (sgr_eff == SGR_RESET) begin
            attr_next = default_attr;
          end else if (sgr_eff inside {[SGR_FG_LO:SGR_FG_HI]}) begin
            attr_next = (attr_eff & ATTR_HI_MASK) | {4'd0, palette[{fg_idx, 2'b00} +: 4]};
          end
        end else begin
          sgr_next = SGR_RESET;
          if (char_code == CH_ESC) begin
            mode_next = MODE_ESC;
          end else if (char_code == CH_PCT) begin
            mode_next = MODE_PCT;
          end else begin
            mode_next = MODE_TEXT;
            r0 = p1.res;
            n  = 2'd1;
            cursor_next = p1.cur;
            col_next    = p1.col;
          end
        end
      end
      MODE_PCT: begin
        mode_next = MODE_TEXT;
        if (char_code == CH_PCT) begin
          r0 = p1.res;
          n  = 2'd1;
          cursor_next = p1.cur;
          col_next    = p1.col;
        end
      end
      default: begin
        if (char_code == CH_ESC) begin
          mode_next = MODE_ESC;
        end else if (char_code == CH_PCT) begin
          mode_next = MODE_PCT;
        end else begin
          mode_next = MODE_TEXT;
          r0 = p1.res;
          n  = 2'd1;
          cursor_next = p1.cur;
          col_next    = p1.col;
        end
      end
    endcase
  end

  always_comb begin
    q_next = q;
    wi     = {1'b0, rem[0]};
    if (pop) begin
      q_next[0] = q[1];
      q_next[1] = q[2];
    end
    if (acc) begin
      if (n != 2'd0) begin
        q_next[wi] = r0;
      end
      if (n == 2'd2) begin
        q_next[wi + 2'd1] = r1;
      end
    end
    cnt_next = rem + (acc ? n : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_TEXT;
      sgr    <= SGR_RESET;
      attr   <= DEFAULT_ATTR_RST;
      cursor <= '0;
      col    <= '0;
      cnt    <= 2'd0;
    end else begin
      cnt <= cnt_next;
      if (acc) begin
        mode   <= mode_next;
        sgr    <= sgr_next;
        attr   <= attr_next;
        cursor <= cursor_next;
        col    <= col_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

  assign cell_write   = q[0].cell_write;
  assign cell_index   = q[0].cell_index;
  assign glyph        = q[0].glyph;
  assign attribute    = q[0].attribute;
  assign screen_clear = q[0].screen_clear;
  assign cursor_index = q[0].cursor_index;

  a_clear_homes: assert property (@(posedge clk) disable iff (rst)
    out_valid && screen_clear |-> cursor_index == '0)
    else $error("screen clear without cursor at home");

  a_newline_blank: assert property (@(posedge clk) disable iff (rst)
    out_valid && !cell_write |-> cell_index == '0 && glyph == 8'd0 && attribute == 8'd0)
    else $error("newline word carries cell data");

  a_cursor_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && cell_write && !screen_clear
      |-> (CW+1)'(cursor_index) == (CW+1)'(cell_index) + 1'b1)
    else $error("cursor did not advance by one cell");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (CW+1)'(cursor) < (CW+1)'(LIMIT))
    else $error("cursor beyond screen");

endmodule
